[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while in reset.
`define YCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Clocked implication: when ante holds, cons must hold in the same cycle.
`define YCC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/ycc_pkg.sv]
`timescale 1ns / 1ps

package ycc_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Configuration registers
	localparam int CFG_W   = 13;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;
	// Register select is paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Line store entry: red, green and blue pair sums
	localparam int SUM_W  = 9;
	localparam int LINE_W = 3 * SUM_W;

	localparam int QUEUE_DEPTH = 4;

	// Luma arithmetic
	localparam int LUMA_ACC_W = 21;
	localparam logic [LUMA_ACC_W-1:0] LUMA_R   = 21'd2104;
	localparam logic [LUMA_ACC_W-1:0] LUMA_G   = 21'd4130;
	localparam logic [LUMA_ACC_W-1:0] LUMA_B   = 21'd802;
	localparam logic [LUMA_ACC_W-1:0] LUMA_OFS = 21'd135168;
	localparam logic [7:0] LUMA_MAX = 8'd235;

	// Chroma arithmetic
	localparam int CHR_ACC_W = 25;
	localparam logic signed [CHR_ACC_W-1:0] CB_R = -25'sd1214;
	localparam logic signed [CHR_ACC_W-1:0] CB_G = -25'sd2384;
	localparam logic signed [CHR_ACC_W-1:0] CB_B = 25'sd3598;
	localparam logic signed [CHR_ACC_W-1:0] CR_R = 25'sd3598;
	localparam logic signed [CHR_ACC_W-1:0] CR_G = -25'sd3013;
	localparam logic signed [CHR_ACC_W-1:0] CR_B = -25'sd585;
	localparam logic signed [CHR_ACC_W-1:0] CHR_OFS = 25'sd1052672;
	localparam logic [7:0] CHR_MIN = 8'd16;
	localparam logic [7:0] CHR_MAX = 8'd240;

	typedef struct packed {
		logic valid;
		logic chroma;
		logic last;
	} ycc_ctl_t;

	typedef struct packed {
		logic [7:0]  luma_value;
		logic [23:0] luma_address;
		logic        chroma_valid;
		logic [7:0]  cb_value;
		logic [7:0]  cr_value;
		logic [21:0] chroma_address;
		logic        frame_end;
	} ycc_result_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Even size, at least 2, at most maxv
	function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
		int e;
		e = int'({v[CFG_W-1:1], 1'b0});
		if (e < 2) e = 2;
		if (e > maxv) e = maxv;
		return e;
	endfunction

	function automatic logic [7:0] luma_clamp(input logic [LUMA_ACC_W-1:0] acc);
		logic [7:0] y;
		y = acc[LUMA_ACC_W-1:13];
		return (y > LUMA_MAX) ? LUMA_MAX : y;
	endfunction

	function automatic logic [7:0] chroma_clamp(input logic signed [CHR_ACC_W-1:0] acc);
		logic signed [CHR_ACC_W-1:0] v;
		v = acc >>> 13;
		if (acc < 0) return CHR_MIN;
		if (v < $signed({17'd0, CHR_MIN})) return CHR_MIN;
		if (v > $signed({17'd0, CHR_MAX})) return CHR_MAX;
		return v[7:0];
	endfunction

endpackage

[rtl/core/ycc_ram.sv]
`timescale 1ns / 1ps

module ycc_ram #(
	parameter int WIDTH = ycc_pkg::LINE_W,
	parameter int DEPTH = ycc_pkg::DEF_MAX_WIDTH / 2
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [ycc_pkg::addr_bits(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [ycc_pkg::addr_bits(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/ycc_front.sv]
`timescale 1ns / 1ps

module ycc_front #(
	parameter int MAX_WIDTH  = ycc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ycc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            accept,
	input  logic [7:0]                                      red,
	input  logic [7:0]                                      green,
	input  logic [7:0]                                      blue,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]                  eff_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]                 eff_h,
	output logic                                            ram_we,
	output logic                                            ram_re,
	output logic [ycc_pkg::addr_bits(MAX_WIDTH/2)-1:0]      line_addr,
	output logic [ycc_pkg::LINE_W-1:0]                      line_sums,
	output ycc_pkg::ycc_ctl_t                               ctl_s1,
	output logic [7:0]                                      red_s1,
	output logic [7:0]                                      green_s1,
	output logic [7:0]                                      blue_s1,
	output logic [ycc_pkg::LINE_W-1:0]                      sums_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]                    col_s1,
	output logic [$clog2(MAX_HEIGHT)-1:0]                   row_s1
);

	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int EH = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int AW = ycc_pkg::addr_bits(MAX_WIDTH / 2);
	localparam int SW = ycc_pkg::SUM_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [23:0]   held_q;
	logic [SW-1:0] sum_r, sum_g, sum_b;
	logic          line_end, frame_last;

	// Pair sums of the held even-column pixel and this one
	assign sum_r = {1'b0, held_q[23:16]} + {1'b0, red};
	assign sum_g = {1'b0, held_q[15:8]} + {1'b0, green};
	assign sum_b = {1'b0, held_q[7:0]} + {1'b0, blue};
	assign line_sums = {sum_r, sum_g, sum_b};

	assign line_end   = (EW'(col_q) + EW'(1)) >= eff_w;
	assign frame_last = line_end && ((EH'(row_q) + EH'(1)) >= eff_h);

	// Even rows fill the line store, odd rows read it back
	assign ram_we    = accept && col_q[0] && !row_q[0];
	assign ram_re    = accept && col_q[0] && row_q[0];
	assign line_addr = AW'(col_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= accept;
			ctl_s1.chroma <= ram_re;
			ctl_s1.last   <= accept && frame_last;
			if (accept) begin
				if (line_end) begin
					col_q <= '0;
					row_q <= frame_last ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!col_q[0]) begin
				held_q <= {red, green, blue};
			end
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			sums_s1  <= line_sums;
			col_s1   <= col_q;
			row_s1   <= row_q;
		end
	end

endmodule

[rtl/core/ycc_calc.sv]
`timescale 1ns / 1ps

module ycc_calc #(
	parameter int MAX_WIDTH  = ycc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ycc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ycc_pkg::ycc_ctl_t                      ctl_s1,
	input  logic [7:0]                             red_s1,
	input  logic [7:0]                             green_s1,
	input  logic [7:0]                             blue_s1,
	input  logic [ycc_pkg::LINE_W-1:0]             sums_s1,
	input  logic [ycc_pkg::LINE_W-1:0]             prev_sums,
	input  logic [$clog2(MAX_WIDTH)-1:0]           col_s1,
	input  logic [$clog2(MAX_HEIGHT)-1:0]          row_s1,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]         eff_w,
	output logic                                   push,
	output ycc_pkg::ycc_result_t                   result
);

	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SW = ycc_pkg::SUM_W;
	localparam int LW = ((RW + EW) > 24) ? (RW + EW + 1) : 25;
	localparam int YW = ycc_pkg::LUMA_ACC_W;
	localparam int AW_C = ycc_pkg::CHR_ACC_W;

	logic [YW-1:0]     y_acc;
	logic [LW-1:0]     luma_addr, chroma_addr;
	logic [SW+1:0]     blk_r, blk_g, blk_b;

	ycc_pkg::ycc_ctl_t ctl_s2;
	logic [7:0]        y_s2;
	logic [23:0]       la_s2;
	logic [21:0]       ca_s2;
	logic [SW-1:0]     avg_r_s2, avg_g_s2, avg_b_s2;

	logic signed [AW_C-1:0] cb_acc, cr_acc, ar, ag, ab;

	assign y_acc = ycc_pkg::LUMA_R * YW'(red_s1) + ycc_pkg::LUMA_G * YW'(green_s1)
		+ ycc_pkg::LUMA_B * YW'(blue_s1) + ycc_pkg::LUMA_OFS;

	assign luma_addr   = LW'(row_s1) * LW'(eff_w) + LW'(col_s1);
	assign chroma_addr = LW'(row_s1 >> 1) * LW'(eff_w >> 1) + LW'(col_s1 >> 1);

	// Block sums with rounding constant; average is bits above the low two
	assign blk_r = (SW+2)'(sums_s1[3*SW-1:2*SW]) + (SW+2)'(prev_sums[3*SW-1:2*SW])
		+ (SW+2)'(2);
	assign blk_g = (SW+2)'(sums_s1[2*SW-1:SW]) + (SW+2)'(prev_sums[2*SW-1:SW])
		+ (SW+2)'(2);
	assign blk_b = (SW+2)'(sums_s1[SW-1:0]) + (SW+2)'(prev_sums[SW-1:0]) + (SW+2)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			y_s2     <= ycc_pkg::luma_clamp(y_acc);
			la_s2    <= luma_addr[23:0];
			ca_s2    <= chroma_addr[21:0];
			avg_r_s2 <= blk_r[SW+1:2];
			avg_g_s2 <= blk_g[SW+1:2];
			avg_b_s2 <= blk_b[SW+1:2];
		end
	end

	assign ar = $signed({{(AW_C-SW){1'b0}}, avg_r_s2});
	assign ag = $signed({{(AW_C-SW){1'b0}}, avg_g_s2});
	assign ab = $signed({{(AW_C-SW){1'b0}}, avg_b_s2});

	assign cb_acc = ycc_pkg::CB_R * ar + ycc_pkg::CB_G * ag + ycc_pkg::CB_B * ab
		+ ycc_pkg::CHR_OFS;
	assign cr_acc = ycc_pkg::CR_R * ar + ycc_pkg::CR_G * ag + ycc_pkg::CR_B * ab
		+ ycc_pkg::CHR_OFS;

	assign push = ctl_s2.valid;

	always_comb begin
		result.luma_value     = y_s2;
		result.luma_address   = la_s2;
		result.chroma_valid   = ctl_s2.chroma;
		result.frame_end      = ctl_s2.last;
		// Zero the chroma fields unless a block completes
		result.cb_value       = ctl_s2.chroma ? ycc_pkg::chroma_clamp(cb_acc) : 8'd0;
		result.cr_value       = ctl_s2.chroma ? ycc_pkg::chroma_clamp(cr_acc) : 8'd0;
		result.chroma_address = ctl_s2.chroma ? ca_s2 : 22'd0;
	end

endmodule

[rtl/core/ycc_outq.sv]
`timescale 1ns / 1ps

module ycc_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_accept,
	input  logic                 push,
	input  ycc_pkg::ycc_result_t push_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output ycc_pkg::ycc_result_t out_data,
	output logic                 in_stall
);

	localparam int DEPTH = ycc_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ycc_pkg::ycc_result_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] fill_q, credit_q;
	logic          pop;

	assign out_valid = fill_q != '0;
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	// Hold off new requests once every slot is spoken for
	assign in_stall  = credit_q == CW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			fill_q   <= fill_q + CW'(push) - CW'(pop);
			credit_q <= credit_q + CW'(in_accept) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/core/rgb_to_ycbcr420_converter_core.sv]
`timescale 1ns / 1ps

// RGB to YCbCr 4:2:0 converter, BT.601 fixed point.
// Input channel: one RGB pixel per request (red, green, blue), raster order,
// accepted when in_valid is high and in_stall is low.
// Output channel: one result per pixel: luma and its plane address, plus Cb,
// Cr and the chroma address on the odd column of an odd row (chroma_valid),
// and frame_end on the last pixel of the frame.
// Frame size comes from the APB registers frame_width (0x0) and frame_height
// (0x4); the low bit is ignored. Write them only while the block is idle.
// A pixel passes the ctl_s1 and ctl_s2 registers into the output queue, which
// raises out_valid. Throughput: one pixel per cycle while in_stall is low; the
// line store of even-row pair sums takes one write or read per odd-column pixel.
// A four-entry output queue holds finished results; in_stall rises only when
// four requests are accepted and not yet taken, so a stalled receiver backs
// up the input after four pixels.
// Reset: counters go to the frame start, size to 640x480, the queue empties.
// The line store is not cleared; every read follows a write of the same entry.

module rgb_to_ycbcr420_converter_core #(
	parameter int MAX_WIDTH  = ycc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ycc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ycc_pkg::PADDR_W-1:0]    paddr,
	input  logic [ycc_pkg::PDATA_W-1:0]    pwdata,
	output logic [ycc_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     luma_value,
	output logic [23:0]                    luma_address,
	output logic                           chroma_valid,
	output logic [7:0]                     cb_value,
	output logic [7:0]                     cr_value,
	output logic [21:0]                    chroma_address,
	output logic                           frame_end
);

	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int EH = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW = ycc_pkg::addr_bits(DEPTH);
	localparam int CFG_W = ycc_pkg::CFG_W;

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic [EW-1:0]    eff_w_q;
	logic [EH-1:0]    eff_h_q;
	logic             cfg_wr, accept;

	logic                      ram_we, ram_re;
	logic [AW-1:0]             line_addr;
	logic [ycc_pkg::LINE_W-1:0] line_sums, prev_sums, sums_s1;
	ycc_pkg::ycc_ctl_t         ctl_s1;
	logic [7:0]                red_s1, green_s1, blue_s1;
	logic [CW-1:0]             col_s1;
	logic [RW-1:0]             row_s1;
	logic                      push;
	ycc_pkg::ycc_result_t      push_data, out_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ycc_pkg::RST_WIDTH;
			frame_height_q <= ycc_pkg::RST_HEIGHT;
			eff_w_q        <= EW'(ycc_pkg::eff_size(ycc_pkg::RST_WIDTH, MAX_WIDTH));
			eff_h_q        <= EH'(ycc_pkg::eff_size(ycc_pkg::RST_HEIGHT, MAX_HEIGHT));
		end else if (cfg_wr) begin
			case (paddr[2])
				ycc_pkg::REG_WIDTH: begin
					frame_width_q <= pwdata[CFG_W-1:0];
					eff_w_q <= EW'(ycc_pkg::eff_size(pwdata[CFG_W-1:0], MAX_WIDTH));
				end
				ycc_pkg::REG_HEIGHT: begin
					frame_height_q <= pwdata[CFG_W-1:0];
					eff_h_q <= EH'(ycc_pkg::eff_size(pwdata[CFG_W-1:0], MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ycc_pkg::REG_WIDTH:  prdata = ycc_pkg::PDATA_W'(frame_width_q);
			ycc_pkg::REG_HEIGHT: prdata = ycc_pkg::PDATA_W'(frame_height_q);
			default:             prdata = '0;
		endcase
	end

	ycc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.eff_w    (eff_w_q),
		.eff_h    (eff_h_q),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.line_addr(line_addr),
		.line_sums(line_sums),
		.ctl_s1   (ctl_s1),
		.red_s1   (red_s1),
		.green_s1 (green_s1),
		.blue_s1  (blue_s1),
		.sums_s1  (sums_s1),
		.col_s1   (col_s1),
		.row_s1   (row_s1)
	);

	ycc_ram #(
		.WIDTH(ycc_pkg::LINE_W),
		.DEPTH(DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(line_addr),
		.wdata(line_sums),
		.re   (ram_re),
		.raddr(line_addr),
		.rdata(prev_sums)
	);

	ycc_calc #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.red_s1   (red_s1),
		.green_s1 (green_s1),
		.blue_s1  (blue_s1),
		.sums_s1  (sums_s1),
		.prev_sums(prev_sums),
		.col_s1   (col_s1),
		.row_s1   (row_s1),
		.eff_w    (eff_w_q),
		.push     (push),
		.result   (push_data)
	);

	ycc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(accept),
		.push     (push),
		.push_data(push_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.in_stall (in_stall)
	);

	assign luma_value     = out_data.luma_value;
	assign luma_address   = out_data.luma_address;
	assign chroma_valid   = out_data.chroma_valid;
	assign cb_value       = out_data.cb_value;
	assign cr_value       = out_data.cr_value;
	assign chroma_address = out_data.chroma_address;
	assign frame_end      = out_data.frame_end;

endmodule

[rtl/core/ycc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ycc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  luma_value,
	input logic [23:0] luma_address,
	input logic        chroma_valid,
	input logic [7:0]  cb_value,
	input logic [7:0]  cr_value,
	input logic [21:0] chroma_address
);

	`YCC_ASSERT_IMPL(a_luma_range, out_valid, luma_value >= 8'd16 && luma_value <= 8'd235, "luma out of range")

	`YCC_ASSERT_IMPL(a_chroma_range, out_valid && chroma_valid, cb_value >= 8'd16 && cb_value <= 8'd240 && cr_value >= 8'd16 && cr_value <= 8'd240, "chroma out of range")

	`YCC_ASSERT_IMPL(a_chroma_zero, out_valid && !chroma_valid, cb_value == 8'd0 && cr_value == 8'd0 && chroma_address == 22'd0, "chroma fields set without a block")

	`YCC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(luma_address), "stalled result changed")

endmodule

bind rgb_to_ycbcr420_converter_core ycc_checker u_ycc_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [ycc_pkg::PADDR_W-1:0] paddr = '0;
	logic [ycc_pkg::PDATA_W-1:0] pwdata = '0;
	logic [ycc_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  red = 8'd0;
	logic [7:0]  green = 8'd0;
	logic [7:0]  blue = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  luma_value;
	logic [23:0] luma_address;
	logic        chroma_valid;
	logic [7:0]  cb_value;
	logic [7:0]  cr_value;
	logic [21:0] chroma_address;
	logic        frame_end;

	rgb_to_ycbcr420_converter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.luma_value(luma_value),
		.luma_address(luma_address),
		.chroma_valid(chroma_valid),
		.cb_value(cb_value),
		.cr_value(cr_value),
		.chroma_address(chroma_address),
		.frame_end(frame_end)
	);

	// Converter state as the pixel stream should leave it
	logic [12:0] frame_width_reg = 13'd640;
	logic [12:0] frame_height_reg = 13'd480;
	int          col_pos = 0;
	int          row_pos = 0;
	logic [23:0] held_rgb = '0;
	logic [26:0] pair_store [0:2047];

	ycc_pkg::ycc_result_t expected_results[$];
	int mismatch_count = 0;
	int pixels_sent = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	// Low bit dropped, clamped to 2..4096
	function automatic int even_dim(input logic [12:0] v);
		int e;
		e = int'({v[12:1], 1'b0});
		if (e < 2) e = 2;
		if (e > 4096) e = 4096;
		return e;
	endfunction

	function automatic logic [7:0] chroma_limit(input int acc);
		int v;
		if (acc < 0) return 8'd16;
		v = acc >>> 13;
		if (v < 16) return 8'd16;
		if (v > 240) return 8'd240;
		return v[7:0];
	endfunction

	function automatic void predict_pixel(input logic [23:0] rgb);
		ycc_pkg::ycc_result_t res;
		int w, h, idx, y, sr, sg, sb, ar, ag, ab;
		logic [26:0] prev;
		logic line_done;
		w = even_dim(frame_width_reg);
		h = even_dim(frame_height_reg);
		idx = col_pos >> 1;
		res = '0;
		y = (2104 * int'(rgb[23:16]) + 4130 * int'(rgb[15:8]) + 802 * int'(rgb[7:0])
			+ 135168) >> 13;
		res.luma_value = (y > 235) ? 8'd235 : y[7:0];
		if (col_pos % 2 == 0) begin
			held_rgb = rgb;
		end else begin
			sr = int'(held_rgb[23:16]) + int'(rgb[23:16]);
			sg = int'(held_rgb[15:8]) + int'(rgb[15:8]);
			sb = int'(held_rgb[7:0]) + int'(rgb[7:0]);
			if (row_pos % 2 == 0) begin
				pair_store[idx] = {sr[8:0], sg[8:0], sb[8:0]};
			end else begin
				prev = pair_store[idx];
				ar = (sr + int'(prev[26:18]) + 2) >> 2;
				ag = (sg + int'(prev[17:9]) + 2) >> 2;
				ab = (sb + int'(prev[8:0]) + 2) >> 2;
				res.chroma_valid = 1'b1;
				res.cb_value = chroma_limit(-1214 * ar - 2384 * ag + 3598 * ab + 1052672);
				res.cr_value = chroma_limit(3598 * ar - 3013 * ag - 585 * ab + 1052672);
				res.chroma_address = 22'((row_pos / 2) * (w / 2) + idx);
			end
		end
		res.luma_address = 24'(row_pos * w + col_pos);
		line_done = col_pos >= w - 1;
		res.frame_end = line_done && row_pos >= h - 1;
		if (line_done) begin
			col_pos = 0;
			row_pos = res.frame_end ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
		expected_results.push_back(res);
	endfunction

	function automatic logic [7:0] pick_component(input int style);
		case (style)
			0: return 8'($urandom_range(0, 255));
			1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: return 8'($urandom_range(0, 1) ? $urandom_range(240, 255)
				: $urandom_range(0, 15));
		endcase
	endfunction

	// Call at a rising edge; returns at the edge that accepted the pixel
	task automatic send_pixel(input logic [23:0] rgb);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		red <= rgb[23:16];
		green <= rgb[15:8];
		blue <= rgb[7:0];
		do @(posedge clk); while (in_stall);
		predict_pixel(rgb);
		pixels_sent++;
	endtask

	// Drop valid and hold off until every outstanding request has come back
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_register(input logic reg_sel, input logic [12:0] want);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[12:0] !== want) begin
			$error("%s readback: expected %0d, got %0d",
				reg_sel == ycc_pkg::REG_WIDTH ? "frame_width" : "frame_height", want, got[12:0]);
			mismatch_count++;
		end
	endtask

	task automatic write_register(input logic reg_sel, input logic [31:0] value);
		wait_for_idle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == ycc_pkg::REG_WIDTH) frame_width_reg = value[12:0];
		else frame_height_reg = value[12:0];
		read_register(reg_sel, value[12:0]);
	endtask

	// Runs to the end of the current frame; with events on, it may change the width at the
	// start of an even row (the line store is refilled before the odd row reads it) or pause
	task automatic send_frame(input int style, input bit events_on);
		do begin
			send_pixel({pick_component(style), pick_component(style), pick_component(style)});
			if (events_on && col_pos == 0 && row_pos % 2 == 0 && row_pos != 0 &&
					$urandom_range(0, 9) == 0)
				write_register(ycc_pkg::REG_WIDTH, $urandom_range(2, 40));
			else if (events_on && $urandom_range(0, 149) == 0)
				wait_for_idle();
		end while (col_pos != 0 || row_pos != 0);
	endtask

	task automatic test_default_size();
		read_register(ycc_pkg::REG_WIDTH, 13'd640);
		read_register(ycc_pkg::REG_HEIGHT, 13'd480);
		repeat (6) send_pixel(24'($urandom));
	endtask

	// Shrink the line mid-row to end it at once, finish a 4x4 frame, then a 2x2; corner colors
	task automatic test_directed_corners();
		logic [13*24-1:0] corners;
		corners = {24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010204,
			24'h081020, 24'h407FFE, 24'hFFFFFF};
		write_register(ycc_pkg::REG_WIDTH, 32'd4);
		write_register(ycc_pkg::REG_HEIGHT, 32'd5);
		for (int i = 12; i >= 0; i--) send_pixel(corners[i*24 +: 24]);
		write_register(ycc_pkg::REG_WIDTH, 32'd0);
		write_register(ycc_pkg::REG_HEIGHT, 32'd1);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
	endtask

	// Oversized width clamps to the widest line; cut the line short and finish on a narrow one
	task automatic test_widest_line();
		write_register(ycc_pkg::REG_WIDTH, 32'h1FFF);
		write_register(ycc_pkg::REG_HEIGHT, 32'd3);
		repeat (300) send_pixel(24'($urandom));
		write_register(ycc_pkg::REG_WIDTH, 32'd8);
		send_frame(0, 1'b0);
	endtask

	// Cut a very tall frame short by lowering the height at an even row
	task automatic test_tallest_frame();
		write_register(ycc_pkg::REG_WIDTH, 32'd2);
		write_register(ycc_pkg::REG_HEIGHT, 32'hFFFF_FFFF);
		repeat (20) send_pixel(24'($urandom));
		write_register(ycc_pkg::REG_HEIGHT, 32'd2);
		send_frame(1, 1'b0);
	endtask

	task automatic test_random_frames();
		int first, w, h;
		first = pixels_sent;
		while (pixels_sent - first < 1400) begin
			case ($urandom_range(0, 6))
				0: w = $urandom_range(0, 3);
				1: w = $urandom_range(41, 200);
				default: w = $urandom_range(2, 40);
			endcase
			h = (w > 40) ? $urandom_range(0, 3) : $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0) w = w | ($urandom & 32'hFFFF_E000);
			if ($urandom_range(0, 3) == 0) h = h | ($urandom & 32'hFFFF_E000);
			if ($urandom_range(0, 1)) begin
				write_register(ycc_pkg::REG_HEIGHT, h);
				if ($urandom_range(0, 4) != 0) write_register(ycc_pkg::REG_WIDTH, w);
			end else begin
				write_register(ycc_pkg::REG_WIDTH, w);
				if ($urandom_range(0, 4) != 0) write_register(ycc_pkg::REG_HEIGHT, h);
			end
			gaps_on = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(1, 2)) send_frame($urandom_range(0, 4), 1'b1);
		end
		gaps_on = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		ycc_pkg::ycc_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding, luma_address %0d", luma_address);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("luma_value", 32'(want.luma_value), 32'(luma_value));
					check_field("luma_address", 32'(want.luma_address), 32'(luma_address));
					check_field("chroma_valid", 32'(want.chroma_valid), 32'(chroma_valid));
					check_field("cb_value", 32'(want.cb_value), 32'(cb_value));
					check_field("cr_value", 32'(want.cr_value), 32'(cr_value));
					check_field("chroma_address", 32'(want.chroma_address),
						32'(chroma_address));
					check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
				end
			end
		end
	end

	// Output backpressure: none, sparse random, periodic, or long holds
	initial begin
		int stall_mode, stall_tick, hold_left;
		bit hold_level;
		stall_mode = 0;
		stall_tick = 0;
		hold_left = 0;
		hold_level = 1'b0;
		forever begin
			@(posedge clk);
			stall_tick++;
			if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= (stall_tick % 7) < 3;
				default: begin
					if (hold_left == 0) begin
						hold_left = $urandom_range(1, 12);
						hold_level = !hold_level;
					end
					hold_left--;
					out_stall <= hold_level;
				end
			endcase
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_size();
		test_directed_corners();
		test_widest_line();
		test_tallest_frame();
		test_random_frames();
		wait_for_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	// Far beyond the slowest legal run of about 2k pixels
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ycc_pkg.sv
rtl/core/ycc_ram.sv
rtl/core/ycc_front.sv
rtl/core/ycc_calc.sv
rtl/core/ycc_outq.sv
rtl/core/rgb_to_ycbcr420_converter_core.sv
rtl/core/ycc_checker.sv
sim/tb_top.sv
